[rtl/core/fcp_pkg.sv]
// Shared constants and types for the FIFO cache with next-line prefetch.
`default_nettype none
package fcp_pkg;
    localparam int MAX_SETS_DEF   = 256;
    localparam int MAX_WAYS_DEF   = 8;
    localparam int ADDR_BITS_DEF  = 48;
    localparam int MAX_OFFSET_BITS = 16;

    localparam logic [1:0] REG_BLOCK_OFFSET = 2'd0;
    localparam logic [1:0] REG_SET_INDEX    = 2'd1;
    localparam logic [1:0] REG_WAYS         = 2'd2;

    // Datapath operations issued by the controller.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_CLEAR,
        OP_READ_MAIN,
        OP_EVAL_MAIN,
        OP_READ_NEXT,
        OP_EVAL_NEXT,
        OP_OUTPUT
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic pref_miss;
        logic clear_last;
    } status_t;
endpackage
`default_nettype wire

[rtl/core/fcp_stream_if.sv]
// Valid/ready stream interface used by both channels.
`default_nettype none
interface fcp_stream_if #(
    parameter int W = 1
);
    logic         valid;
    logic         ready;
    logic [W-1:0] payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

[rtl/core/fcp_ctrl.sv]
// Controller state machine sequencing one access through both caches.
`default_nettype none
module fcp_ctrl
    import fcp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  wire logic    out_ready,
    output cmd_t         cmd,
    input  wire status_t stat
);
    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_EVAL_MAIN, S_READ_NEXT, S_EVAL_NEXT, S_OUT
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   done_out;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign done_out  = out_valid_reg && out_ready;

    always_comb
    begin
        cmd.op = OP_NONE;
        case (state_reg)
            S_CLEAR:     cmd.op = OP_CLEAR;
            S_IDLE:      if (in_valid) cmd.op = OP_READ_MAIN;
            S_EVAL_MAIN: cmd.op = OP_EVAL_MAIN;
            S_READ_NEXT: cmd.op = OP_READ_NEXT;
            S_EVAL_NEXT: cmd.op = OP_EVAL_NEXT;
            S_OUT:       if (!out_valid_reg || out_ready) cmd.op = OP_OUTPUT;
            default:     cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // A new result replaces the one leaving in the same cycle.
            if (state_reg == S_OUT && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (done_out)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_CLEAR:     if (stat.clear_last) state_reg <= S_IDLE;
                S_IDLE:      if (in_valid) state_reg <= S_EVAL_MAIN;
                S_EVAL_MAIN: state_reg <= stat.pref_miss ? S_READ_NEXT : S_OUT;
                S_READ_NEXT: state_reg <= S_EVAL_NEXT;
                S_EVAL_NEXT: state_reg <= S_OUT;
                S_OUT:       if (!out_valid_reg || out_ready) state_reg <= S_IDLE;
                default:     state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg)
        else $error("result dropped while stalled");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !in_ready)
        else $error("accept while busy");
    a_next_follows: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ_NEXT |=> state_reg == S_EVAL_NEXT)
        else $error("prefetch sequence broken");
`endif
endmodule
`default_nettype wire

[rtl/core/fcp_datapath.sv]
// Tag, valid and age stores of both caches plus the event counters.
`default_nettype none
module fcp_datapath
    import fcp_pkg::*;
#(
    parameter int MAX_SETS  = MAX_SETS_DEF,
    parameter int MAX_WAYS  = MAX_WAYS_DEF,
    parameter int ADDR_BITS = ADDR_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cmd_t                 cmd,
    output status_t                   stat,
    input  wire logic                 cfg_we,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [4:0]           cfg_data,
    input  wire logic [ADDR_BITS-1:0] in_addr,
    input  wire logic                 in_write,
    output logic [3+8*32-1:0]         result
);
    localparam int SB  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int SMX = $clog2(MAX_SETS + 1) - 1;
    localparam int WB  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WCB = $clog2(MAX_WAYS + 1);
    localparam int EW  = ADDR_BITS + 1 + WB;
    localparam int RW  = MAX_WAYS * EW;

    logic [4:0] boff_reg;
    logic [3:0] sidx_reg;
    logic [3:0] ways_reg;

    // Row stores: one set per entry, each way packed as {age, valid, tag}.
    logic [RW-1:0] prow_mem [MAX_SETS];
    logic [RW-1:0] frow_mem [MAX_SETS];

    logic [RW-1:0]        prow_reg, frow_reg;
    logic [ADDR_BITS-1:0] addr_reg, tag_reg, ntag_reg;
    logic [SB-1:0]        set_reg, nset_reg, clr_idx_reg;
    logic                 wr_reg;
    logic                 phit_reg, fhit_reg, done_reg;
    logic [31:0]          cnt_reg [8];
    logic [3+8*32-1:0]    result_reg;

    logic [4:0]           b_eff;
    logic [3:0]           s_eff;
    logic [WCB-1:0]       w_eff;
    logic [ADDR_BITS-1:0] addr_next, a_tag, a_next_addr, n_tag, f_tag;
    logic [SB-1:0]        a_set, n_set;
    logic                 ph_c, fh_c, nh_c;
    logic [RW-1:0]        p_fill, f_fill;

    always_comb
    begin
        b_eff = (boff_reg > 5'(MAX_OFFSET_BITS)) ? 5'(MAX_OFFSET_BITS) : boff_reg;
        s_eff = (sidx_reg > 4'(SMX)) ? 4'(SMX) : sidx_reg;
        if (ways_reg == 4'd0)
            w_eff = WCB'(1);
        else if (32'(ways_reg) > MAX_WAYS)
            w_eff = WCB'(MAX_WAYS);
        else
            w_eff = WCB'(ways_reg);
    end

    function automatic logic [SB-1:0] set_of(input logic [ADDR_BITS-1:0] a,
                                             input logic [4:0] b, input logic [3:0] s);
        logic [ADDR_BITS-1:0] sh;
        sh = (a >> b) & ((ADDR_BITS'(1) << s) - ADDR_BITS'(1));
        return sh[SB-1:0];
    endfunction

    function automatic logic [ADDR_BITS-1:0] tag_of(input logic [ADDR_BITS-1:0] a,
                                                    input logic [4:0] b, input logic [3:0] s);
        return a >> (6'(b) + 6'(s));
    endfunction

    function automatic logic hit_of(input logic [RW-1:0] row,
                                    input logic [ADDR_BITS-1:0] tag,
                                    input logic [WCB-1:0] nw);
        logic h;
        h = 1'b0;
        for (int w = 0; w < MAX_WAYS; w++)
            if (w < 32'(nw) && row[w*EW+ADDR_BITS] && row[w*EW +: ADDR_BITS] == tag)
                h = 1'b1;
        return h;
    endfunction

    // Ages the valid ways in use and places the tag in the highest free way,
    // else in the oldest valid way with ties going to the higher index.
    function automatic logic [RW-1:0] fill_row(input logic [RW-1:0] row,
                                               input logic [ADDR_BITS-1:0] tag,
                                               input logic [WCB-1:0] nw);
        logic [RW-1:0] r;
        logic          free;
        logic [WB-1:0] maxage;
        logic [WB-1:0] victim;
        logic [WB-1:0] place;
        logic [WB-1:0] age;
        r      = row;
        free   = 1'b0;
        maxage = '0;
        victim = '0;
        place  = '0;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (w < 32'(nw))
            begin
                age = row[w*EW+ADDR_BITS+1 +: WB];
                if (row[w*EW+ADDR_BITS])
                begin
                    if (age >= maxage)
                    begin
                        maxage = age;
                        victim = WB'(w);
                    end
                    if (age < WB'(MAX_WAYS - 1))
                        r[w*EW+ADDR_BITS+1 +: WB] = age + WB'(1);
                end
                else
                begin
                    free  = 1'b1;
                    place = WB'(w);
                end
            end
        end
        if (!free)
            place = victim;
        for (int w = 0; w < MAX_WAYS; w++)
            if (WB'(w) == place)
                r[w*EW +: EW] = {WB'(0), 1'b1, tag};
        return r;
    endfunction

    assign a_set       = set_of(in_addr, b_eff, s_eff);
    assign a_tag       = tag_of(in_addr, b_eff, s_eff);
    assign a_next_addr = addr_reg + (ADDR_BITS'(1) << b_eff);
    assign n_set       = set_of(a_next_addr, b_eff, s_eff);
    assign n_tag       = tag_of(a_next_addr, b_eff, s_eff);
    assign addr_next   = in_addr;

    assign ph_c   = hit_of(prow_reg, tag_reg, w_eff);
    assign fh_c   = hit_of(frow_reg, tag_reg, w_eff);
    assign nh_c   = hit_of(frow_reg, ntag_reg, w_eff);
    assign f_tag  = (cmd.op == OP_EVAL_NEXT) ? ntag_reg : tag_reg;
    assign p_fill = fill_row(prow_reg, tag_reg, w_eff);
    assign f_fill = fill_row(frow_reg, f_tag, w_eff);

    assign stat.pref_miss  = !fh_c;
    assign stat.clear_last = (clr_idx_reg == SB'(MAX_SETS - 1));
    assign result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            boff_reg <= 5'd4;
            sidx_reg <= 4'd0;
            ways_reg <= 4'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BLOCK_OFFSET: boff_reg <= cfg_data;
                REG_SET_INDEX:    sidx_reg <= cfg_data[3:0];
                REG_WAYS:         ways_reg <= cfg_data[3:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_CLEAR:
            begin
                prow_mem[clr_idx_reg] <= '0;
                frow_mem[clr_idx_reg] <= '0;
            end
            OP_READ_MAIN:
            begin
                prow_reg <= prow_mem[a_set];
                frow_reg <= frow_mem[a_set];
                addr_reg <= addr_next;
                set_reg  <= a_set;
                tag_reg  <= a_tag;
                wr_reg   <= in_write;
            end
            OP_EVAL_MAIN:
            begin
                if (!ph_c)
                    prow_mem[set_reg] <= p_fill;
                if (!fh_c)
                    frow_mem[set_reg] <= f_fill;
                nset_reg <= n_set;
                ntag_reg <= n_tag;
            end
            OP_READ_NEXT: frow_reg <= frow_mem[nset_reg];
            OP_EVAL_NEXT:
                if (!nh_c)
                    frow_mem[nset_reg] <= f_fill;
            OP_OUTPUT:
            begin
                result_reg[0] <= phit_reg;
                result_reg[1] <= fhit_reg;
                result_reg[2] <= done_reg;
                for (int k = 0; k < 8; k++)
                    result_reg[3+32*k +: 32] <= cnt_reg[k];
            end
            default: ;
        endcase
    end

    // Clearing pointer, flags and counter updates.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg <= '0;
            for (int k = 0; k < 8; k++)
                cnt_reg[k] <= '0;
            phit_reg <= 1'b0;
            fhit_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            case (cmd.op)
                OP_CLEAR:
                    clr_idx_reg <= clr_idx_reg + SB'(1);
                OP_EVAL_MAIN:
                begin
                    phit_reg <= ph_c;
                    fhit_reg <= fh_c;
                    done_reg <= 1'b0;
                    if (ph_c)
                        cnt_reg[2] <= cnt_reg[2] + 32'd1;
                    else
                    begin
                        cnt_reg[3] <= cnt_reg[3] + 32'd1;
                        cnt_reg[0] <= cnt_reg[0] + 32'd1;
                    end
                    if (wr_reg)
                    begin
                        cnt_reg[1] <= cnt_reg[1] + 32'd1;
                        cnt_reg[5] <= cnt_reg[5] + 32'd1;
                    end
                    if (fh_c)
                        cnt_reg[6] <= cnt_reg[6] + 32'd1;
                    else
                    begin
                        cnt_reg[7] <= cnt_reg[7] + 32'd1;
                        cnt_reg[4] <= cnt_reg[4] + 32'd1;
                    end
                end
                OP_EVAL_NEXT:
                begin
                    if (!nh_c)
                    begin
                        done_reg   <= 1'b1;
                        cnt_reg[4] <= cnt_reg[4] + 32'd1;
                    end
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_done_implies_miss: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_EVAL_NEXT |-> !fhit_reg)
        else $error("prefetch after a hit");
    a_miss_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_EVAL_MAIN && !ph_c |=> cnt_reg[3] == $past(cnt_reg[3]) + 32'd1)
        else $error("miss counter not advanced");
    a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_EVAL_MAIN && ph_c |=> cnt_reg[2] == $past(cnt_reg[2]) + 32'd1)
        else $error("hit counter not advanced");
`endif
endmodule
`default_nettype wire

[rtl/core/fifo_cache_with_next_line_prefetch.sv]
// Top level: two FIFO caches, one with next-line prefetch, behind streams.
`default_nettype none
// Each access is compared against a plain write-through set-associative cache
// and a second one that prefetches the next block on its own miss; one result
// carrying both hit flags, the prefetch flag and eight running counters comes
// back per access. An access holds the controller in more states when the
// prefetching cache misses than when it hits, since the next block's set
// needs its own read of the single-port row store. A finished result waits in
// an output register so the next access can start; a stalled receiver holds
// the controller in its output state once a second result is ready. Tags,
// valid bits and ages of one set share a row, so after reset the controller
// clears both row stores one set at a time before it accepts an access.
module fifo_cache_with_next_line_prefetch
    import fcp_pkg::*;
#(
    parameter int MAX_SETS  = MAX_SETS_DEF,
    parameter int MAX_WAYS  = MAX_WAYS_DEF,
    parameter int ADDR_BITS = ADDR_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    fcp_stream_if.sink       in,
    fcp_stream_if.source     out,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [4:0]  cfg_data
);
    cmd_t    cmd;
    status_t stat;

    fcp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in.valid),
        .in_ready  (in.ready),
        .out_valid (out.valid),
        .out_ready (out.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    fcp_datapath #(
        .MAX_SETS  (MAX_SETS),
        .MAX_WAYS  (MAX_WAYS),
        .ADDR_BITS (ADDR_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_addr   (in.payload[ADDR_BITS-1:0]),
        .in_write  (in.payload[ADDR_BITS]),
        .result    (out.payload)
    );
endmodule
`default_nettype wire

[test/fifo_cache_with_next_line_prefetch_tb.sv]
// Self-checking testbench for the FIFO cache pair with next-line prefetch.
`default_nettype none
module fifo_cache_with_next_line_prefetch_tb;
    import fcp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETS = MAX_SETS_DEF;
    localparam int WAYS = MAX_WAYS_DEF;

    typedef struct packed {
        logic        wr;
        logic [47:0] addr;
    } access_t;

    typedef struct packed {
        logic [7:0][31:0] cnt;
        logic             prefetch_done;
        logic             pref_hit;
        logic             plain_hit;
    } outcome_t;

    typedef struct {
        logic [47:0] addr;
        logic        wr;
        bit          known;
        logic [2:0]  flags;
    } stim_row_t;

    typedef struct {
        logic [47:0] tag[SETS*WAYS];
        bit          vld[SETS*WAYS];
        logic [2:0]  age[SETS*WAYS];
    } cache_img_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_index = REG_BLOCK_OFFSET;
    logic [4:0] cfg_data = '0;

    fcp_stream_if #(.W($bits(access_t)))  acc_if ();
    fcp_stream_if #(.W($bits(outcome_t))) res_if ();

    fifo_cache_with_next_line_prefetch i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in        (acc_if.sink),
        .out       (res_if.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    cache_img_t  plain_img, pref_img;
    logic [31:0] run_cnt[8];
    logic [4:0]  offset_bits;
    logic [3:0]  index_bits;
    logic [3:0]  way_count;
    outcome_t    expected_q[$];
    logic [2:0]  known_flags_q[$];
    bit          known_q[$];
    int          errors = 0;
    int          results_seen = 0;
    int          hold_cycles = 0;
    int          prefetches = 0;
    int          plain_hits = 0;

    task automatic report(input string what, input logic [47:0] got, input logic [47:0] want);
        $display("mismatch #%0d on %s: got %0h, expected %0h", results_seen, what, got, want);
        errors++;
    endtask

    function automatic bit probe(input cache_img_t c, input int set, input logic [47:0] tag,
                                 input int nways);
        for (int w = 0; w < nways; w++)
            if (c.vld[set*WAYS+w] && c.tag[set*WAYS+w] == tag)
                return 1'b1;
        return 1'b0;
    endfunction

    // FIFO placement: the highest free way, else the oldest valid way, ties to the top.
    task automatic install(inout cache_img_t c, input int set, input logic [47:0] tag,
                           input int nways);
        int victim;
        int slot;
        int oldest;
        bit has_free;
        victim = 0;
        slot = 0;
        oldest = 0;
        has_free = 1'b0;
        for (int w = 0; w < nways; w++)
        begin
            if (c.vld[set*WAYS+w])
            begin
                if (c.age[set*WAYS+w] >= oldest)
                begin
                    oldest = c.age[set*WAYS+w];
                    victim = w;
                end
                if (c.age[set*WAYS+w] < WAYS-1)
                    c.age[set*WAYS+w]++;
            end
            else
            begin
                has_free = 1'b1;
                slot = w;
            end
        end
        if (!has_free)
            slot = victim;
        c.tag[set*WAYS+slot] = tag;
        c.vld[set*WAYS+slot] = 1'b1;
        c.age[set*WAYS+slot] = '0;
    endtask

    task automatic predict_access(input access_t a, output outcome_t o);
        int b;
        int s;
        int nways;
        int set;
        int nset;
        logic [47:0] tag;
        logic [47:0] ntag;
        logic [47:0] nxt;
        bit ph;
        bit fh;
        bit pf;
        b = (offset_bits > MAX_OFFSET_BITS) ? MAX_OFFSET_BITS : offset_bits;
        s = (index_bits > 8) ? 8 : index_bits;
        nways = (way_count == 0) ? 1 : ((way_count > WAYS) ? WAYS : way_count);
        set = int'((a.addr >> b) & ((48'd1 << s) - 48'd1));
        tag = a.addr >> (b + s);
        pf = 1'b0;
        ph = probe(plain_img, set, tag, nways);
        if (ph)
            run_cnt[2]++;
        else
        begin
            run_cnt[3]++;
            run_cnt[0]++;
            install(plain_img, set, tag, nways);
        end
        if (a.wr)
            run_cnt[1]++;
        fh = probe(pref_img, set, tag, nways);
        if (fh)
            run_cnt[6]++;
        else
        begin
            nxt = a.addr + (48'd1 << b);
            nset = int'((nxt >> b) & ((48'd1 << s) - 48'd1));
            ntag = nxt >> (b + s);
            run_cnt[7]++;
            run_cnt[4]++;
            install(pref_img, set, tag, nways);
            if (!probe(pref_img, nset, ntag, nways))
            begin
                run_cnt[4]++;
                install(pref_img, nset, ntag, nways);
                pf = 1'b1;
            end
        end
        if (a.wr)
            run_cnt[5]++;
        o.plain_hit = ph;
        o.pref_hit = fh;
        o.prefetch_done = pf;
        for (int k = 0; k < 8; k++)
            o.cnt[k] = run_cnt[k];
        prefetches += pf;
        plain_hits += ph;
    endtask

    task automatic send_access(input logic [47:0] addr, input logic wr, input bit known,
                               input logic [2:0] flags);
        int gap;
        access_t a;
        outcome_t o;
        gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 13) : 0;
        if (gap > 0)
        begin
            acc_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        a.addr = addr;
        a.wr = wr;
        acc_if.valid <= 1'b1;
        acc_if.payload <= a;
        @(posedge clk);
        while (!acc_if.ready)
            @(posedge clk);
        predict_access(a, o);
        expected_q.push_back(o);
        known_q.push_back(known);
        known_flags_q.push_back(flags);
    endtask

    task automatic drain();
        acc_if.valid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [4:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            REG_BLOCK_OFFSET: offset_bits = val;
            REG_SET_INDEX:    index_bits = val[3:0];
            REG_WAYS:         way_count = val[3:0];
            default:          ;
        endcase
    endtask

    task automatic configure(input logic [4:0] ob, input logic [4:0] sb, input logic [4:0] wc);
        write_reg(REG_BLOCK_OFFSET, ob);
        write_reg(REG_SET_INDEX, sb);
        write_reg(REG_WAYS, wc);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly addresses near a few hot regions, so that lines get reused and evicted.
    function automatic logic [47:0] pick_addr(input logic [47:0] hot[4]);
        logic [47:0] r;
        r = 48'({$urandom(), $urandom()});
        case ($urandom_range(0, 9))
            0, 1:    return r;
            2:       return 48'hFFFF_FFFF_FFFF - $urandom_range(0, 4095);
            default: return hot[$urandom_range(0, 3)] + $urandom_range(0, 16383);
        endcase
    endfunction

    // Receiver: random stalls, plus a long hold-off when one is requested.
    initial
    begin
        int w;
        res_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            w = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 13) : 0;
            if (w > 0 || hold_cycles > 0)
            begin
                res_if.ready <= 1'b0;
                repeat (w) @(posedge clk);
                while (hold_cycles > 0)
                begin
                    @(posedge clk);
                    hold_cycles--;
                end
            end
            res_if.ready <= 1'b1;
            @(posedge clk);
            while (!res_if.valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        outcome_t got;
        outcome_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            got = res_if.payload;
            results_seen++;
            if (expected_q.size() == 0)
            begin
                $display("result transfer with nothing expected");
                errors++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (known_q.pop_front())
                begin
                    if ({got.plain_hit, got.pref_hit, got.prefetch_done}
                        !== known_flags_q[0])
                        report("typed-in flags", {got.plain_hit, got.pref_hit,
                               got.prefetch_done}, known_flags_q[0]);
                end
                void'(known_flags_q.pop_front());
                if (got.plain_hit !== want.plain_hit)
                    report("plain_hit", got.plain_hit, want.plain_hit);
                if (got.pref_hit !== want.pref_hit)
                    report("pref_hit", got.pref_hit, want.pref_hit);
                if (got.prefetch_done !== want.prefetch_done)
                    report("prefetch_done", got.prefetch_done, want.prefetch_done);
                for (int k = 0; k < 8; k++)
                    if (got.cnt[k] !== want.cnt[k])
                        report($sformatf("counter %0d", k), got.cnt[k], want.cnt[k]);
            end
        end
    end

    initial
    begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        stim_row_t rows[$];
        logic [47:0] hot[4];
        logic [4:0] phases[8][3];
        acc_if.valid <= 1'b0;
        acc_if.payload <= '0;
        for (int i = 0; i < SETS*WAYS; i++)
        begin
            plain_img.vld[i] = 1'b0;
            plain_img.age[i] = '0;
            plain_img.tag[i] = '0;
            pref_img.vld[i] = 1'b0;
            pref_img.age[i] = '0;
            pref_img.tag[i] = '0;
        end
        foreach (run_cnt[k])
            run_cnt[k] = '0;
        offset_bits = 5'd4;
        index_bits = 4'd0;
        way_count = 4'd1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset geometry first: 16-byte blocks, one set, one way.
        rows = '{
            '{48'h0000_0000_0000, 1'b0, 1'b1, 3'b001},
            '{48'h0000_0000_0000, 1'b1, 1'b1, 3'b101},
            '{48'h0000_0000_000F, 1'b0, 1'b1, 3'b101},
            '{48'h0000_0000_0010, 1'b1, 1'b1, 3'b010},
            '{48'hFFFF_FFFF_FFFF, 1'b0, 1'b0, 3'b000},
            '{48'hFFFF_FFFF_FFF0, 1'b1, 1'b0, 3'b000},
            '{48'h0000_0000_0000, 1'b0, 1'b0, 3'b000},
            '{48'h8000_0000_0000, 1'b1, 1'b0, 3'b000},
            '{48'h7FFF_FFFF_FFFF, 1'b0, 1'b0, 3'b000},
            '{48'h5555_5555_5555, 1'b1, 1'b0, 3'b000},
            '{48'hAAAA_AAAA_AAAA, 1'b0, 1'b0, 3'b000},
            '{48'hAAAA_AAAA_AAAA, 1'b1, 1'b0, 3'b000}
        };
        foreach (rows[i])
            send_access(rows[i].addr, rows[i].wr, rows[i].known, rows[i].flags);
        drain();

        // Geometries, the extremes and the out-of-range codes among them.
        phases = '{
            '{5'd0, 5'd0, 5'd1}, '{5'd16, 5'd8, 5'd8}, '{5'd31, 5'd15, 5'd15},
            '{5'd4, 5'd2, 5'd0}, '{5'd2, 5'd3, 5'd4}, '{5'd6, 5'd1, 5'd2},
            '{5'd1, 5'd8, 5'd3}, '{5'd17, 5'd9, 5'd9}
        };
        foreach (phases[p])
        begin
            configure(phases[p][0], phases[p][1], phases[p][2]);
            foreach (hot[h])
                hot[h] = 48'({$urandom(), $urandom()});
            for (int n = 0; n < 215; n++)
            begin
                if (p == 1 && n == 60)
                    hold_cycles = 300;
                if (p == 4 && n == 100)
                    drain();
                send_access(pick_addr(hot), 1'($urandom_range(0, 1)), 1'b0, 3'b000);
            end
            drain();
        end

        $display("covered %0d accesses over %0d geometries: %0d plain hits, %0d prefetches",
                 results_seen, 9, plain_hits, prefetches);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire

[filelist.f]
rtl/core/fcp_pkg.sv
rtl/core/fcp_stream_if.sv
rtl/core/fcp_ctrl.sv
rtl/core/fcp_datapath.sv
rtl/core/fifo_cache_with_next_line_prefetch.sv
test/fifo_cache_with_next_line_prefetch_tb.sv
